[src/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_FOLD  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_PAD2  = 6'b100000
  } sha_state_e;

  // controller to datapath
  typedef struct packed {
    logic       put;        // write one byte into the window
    logic [5:0] put_pos;
    logic [7:0] put_byte;
    logic       count_inc;  // advance the byte count
    logic       start;      // load working vars from hash words
    logic       round;      // run one compression round
    logic [5:0] round_idx;
    logic       fold;       // add working vars into hash words
    logic       pad_fill;   // fill window with 0x80/zeros/length
    logic       pad_mark;   // place 0x80 at the current position
    logic       pad_len;    // write the bit length words
    logic       restart;    // reset hash words and count
  } sha_cmd_t;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

endpackage

[src/sha_datapath.sv]
`timescale 1ns / 1ps
module sha_datapath import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sha_cmd_t   cmd_i,
  output logic [5:0] pos_o,       // byte count mod 64
  input  logic [2:0] rd_idx_i,
  output word_t      hash_o
);

  word_t       w_q [16];
  word_t       v_q [8];
  word_t       h_q [8];
  logic [60:0] cnt_q;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t       wv, w2, w15, s0, s1, t1, t2, e, a;
  logic [63:0] bits;
  logic [5:0]  r;

  assign pos_o  = cnt_q[5:0];
  assign hash_o = h_q[rd_idx_i];
  assign bits   = {cnt_q, 3'b000};
  assign r      = cmd_i.round_idx;

  // schedule word and round function
  always_comb begin
    w2  = w_q[4'(r - 6'd2)];
    w15 = w_q[4'(r - 6'd15)];
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    if (r < 6'd16) begin
      wv = w_q[r[3:0]];
    end else begin
      wv = s1 + w_q[4'(r - 6'd7)] + s0 + w_q[r[3:0]];
    end
    e  = v_q[4];
    a  = v_q[0];
    t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_q[5]) ^ (~e & v_q[6])) + RoundK[r] + wv;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // window: byte writes, padding and schedule update
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      w_q[cmd_i.put_pos[5:2]][(3 - cmd_i.put_pos[1:0]) * 8 +: 8] <= cmd_i.put_byte;
    end
    if (cmd_i.pad_fill) begin
      for (int p = 0; p < 64; p++) begin
        if (cmd_i.pad_mark && 6'(p) == cnt_q[5:0]) begin
          w_q[4'(p / 4)][(3 - p % 4) * 8 +: 8] <= PadMark;
        end else if ((cmd_i.pad_mark && 6'(p) > cnt_q[5:0]) || !cmd_i.pad_mark) begin
          w_q[4'(p / 4)][(3 - p % 4) * 8 +: 8] <= 8'h00;
        end
      end
      if (cmd_i.pad_len) begin
        w_q[14] <= bits[63:32];
        w_q[15] <= bits[31:0];
      end
    end
    if (cmd_i.round && r >= 6'd16) begin
      w_q[r[3:0]] <= wv;
    end
  end

  // working variables, hash words and byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= '0;
        h_q[i] <= InitHash[i];
      end
      cnt_q <= '0;
    end else begin
      if (cmd_i.start) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (cmd_i.round) begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
      end
      if (cmd_i.restart) begin
        cnt_q <= '0;
      end else if (cmd_i.count_inc) begin
        cnt_q <= cnt_q + 61'd1;
      end
    end
  end

endmodule

[src/sha_ctrl.sv]
`timescale 1ns / 1ps
module sha_ctrl import sha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       in_empty_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_idx_o,
  input  logic [5:0] pos_i,
  output sha_cmd_t   cmd_o
);

  sha_state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       fin_q, fin_d;   // message ended, block(s) after this one pad
  logic       xtra_q, xtra_d; // the running block leaves the length to an extra pad block
  logic       done_q, done_d; // set when the running block carries the length
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_idx_o   = idx_q;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    fin_d   = fin_q;
    xtra_d  = xtra_q;
    cmd_o   = '0;
    cmd_o.put_pos   = pos_i;
    cmd_o.put_byte  = in_byte_i;
    cmd_o.round_idx = rnd_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (!in_empty_i) begin
            cmd_o.put       = 1'b1;
            cmd_o.count_inc = 1'b1;
          end
          fin_d = in_last_i;
          if (!in_empty_i && pos_i == 6'd63) begin
            // full block: compress, then pad if last
            cmd_o.start = 1'b1;
            xtra_d      = 1'b0;
            rnd_d       = '0;
            state_d     = ST_RUN;
          end else if (in_last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (xtra_q) begin
          state_d = ST_PAD2;
        end else begin
          // byte count still at block edge: pad block follows
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        // 0x80 at pos, zeros after; length if room
        cmd_o.pad_fill = 1'b1;
        cmd_o.pad_mark = 1'b1;
        cmd_o.pad_len  = (pos_i < LenPos);
        cmd_o.start    = 1'b1;
        xtra_d         = (pos_i >= LenPos);
        rnd_d          = '0;
        state_d        = ST_RUN;
      end
      ST_PAD2: begin
        // all zeros plus length
        cmd_o.pad_fill = 1'b1;
        cmd_o.pad_len  = 1'b1;
        cmd_o.start    = 1'b1;
        xtra_d         = 1'b0;
        fin_d          = 1'b1;
        rnd_d          = '0;
        state_d        = ST_RUN;
        idx_d          = '0;
        // final block is marked through done; outputs follow next fold
      end
      ST_OUT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.restart = 1'b1;
            fin_d         = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // after the final (length) block go to output
    if (state_q == ST_FOLD && fin_q && done_q) state_d = ST_OUT;
  end

  // track whether the running block carries the length
  always_comb begin
    done_d = done_q;
    if (state_q == ST_PAD)  done_d = (pos_i < LenPos);
    if (state_q == ST_PAD2) done_d = 1'b1;
    if (state_q == ST_IDLE) done_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
      fin_q   <= 1'b0;
      xtra_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= (state_d == ST_OUT && state_q != ST_OUT) ? 3'd0 : idx_d;
      fin_q   <= fin_d;
      xtra_q  <= xtra_d;
      done_q  <= done_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN && rnd_q == 6'd63 |=> state_q == ST_FOLD)
    else $error("round count slip");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && out_ready_i && idx_q == 3'd7 |=> state_q == ST_IDLE)
    else $error("digest not closed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PAD2 |-> $past(state_q) == ST_FOLD)
    else $error("extra pad out of order");

endmodule

[src/sha256_hash_engine.sv]
`timescale 1ns / 1ps
// SHA-256 engine fed one message byte per transfer. A plain byte is written
// into the block window; the 64th byte of a block starts a compression of 64
// rounds plus a fold step, during which no byte is taken, since a single round
// unit does the rounds one after another. The final transfer adds a padding
// block (a fill step, then rounds and fold), and a second one when 56 or more
// bytes of the last block are used. Then the eight digest words leave, word
// 0 first, one per output transfer, and the hash restarts.
module sha256_hash_engine import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // empty_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zeros
  output logic        m_axis_tlast    // last_word
);

  sha_cmd_t   cmd;
  logic [5:0] pos;
  logic [2:0] idx;
  word_t      hw;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_empty_i (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_idx_o  (idx),
    .pos_i      (pos),
    .cmd_o      (cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i   (cmd),
    .pos_o   (pos),
    .rd_idx_i(idx),
    .hash_o  (hw)
  );

  assign m_axis_tdata = {5'b0, idx, hw};
  assign m_axis_tlast = (idx == 3'd7);

endmodule
